@@ hdl/static_linked_list_engine_assert.svh @@
// ----------------------------------------------------------------------------
// Static linked list engine assertion macros
// Shared property forms used by the engine's checks, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef STATIC_LINKED_LIST_ENGINE_ASSERT_SVH
`define STATIC_LINKED_LIST_ENGINE_ASSERT_SVH

// same-cycle implication
`define SLL_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("static_linked_list_engine: check failed");

// next-cycle implication
`define SLL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("static_linked_list_engine: check failed");

`endif

@@ hdl/sll_pkg.sv @@
// ----------------------------------------------------------------------------
// Static linked list engine package
// Sizes, codes and node store request/response types.
// ----------------------------------------------------------------------------
package sll_pkg;

	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int LEN_W      = ADDR_W + 1;
	localparam int CAP        = DEPTH - 2;

	localparam int FUNC_W = 3;
	localparam int POS_W  = 6;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 3;

	typedef logic [ADDR_W-1:0]     addr_t;
	typedef logic [DATA_WIDTH-1:0] data_t;
	typedef logic [LEN_W-1:0]      len_t;

	localparam addr_t NIL        = '0;
	localparam addr_t FIRST_NODE = addr_t'(2);

	typedef enum logic [FUNC_W-1:0] {
		FN_APPEND = 3'd0,
		FN_INSERT = 3'd1,
		FN_DELETE = 3'd2,
		FN_SEARCH = 3'd3,
		FN_READ   = 3'd4
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_BADPOS   = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef struct packed {
		logic  rd_en;
		addr_t rd_addr;
		logic  wr_next_en;
		logic  wr_data_en;
		addr_t wr_addr;
		addr_t wr_next;
		data_t wr_data;
	} mem_req_t;

	typedef struct packed {
		addr_t next;
		data_t data;
	} mem_rsp_t;

endpackage

@@ hdl/static_linked_list_engine.sv @@
// ----------------------------------------------------------------------------
// Static linked list engine
// Array-backed singly linked list with a free list: append, insert, delete,
// search and read by 1-based position, one status word per command.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy stays high until
// the result word, which is shown for exactly one cycle with done high and
// must be captured then. Accepted commands walk the list through the node store,
// whose single read port has registered read data, so each link followed passes
// a request state and a wait state. Commands rejected as full, empty or bad
// position raise done in the cycle after the one that takes them. No clearing
// pass is needed after reset; a new command may start in the cycle that done
// is high.
module static_linked_list_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [sll_pkg::FUNC_W-1:0] func,
	input  logic [sll_pkg::POS_W-1:0]  position,
	input  logic [sll_pkg::VAL_W-1:0]  item_value,
	output logic                       done,
	output logic [sll_pkg::STAT_W-1:0] status,
	output logic [sll_pkg::VAL_W-1:0]  result_value,
	output logic [sll_pkg::POS_W-1:0]  found_position
);
	import sll_pkg::*;

	`include "static_linked_list_engine_assert.svh"

	typedef enum logic [3:0] {
		S_IDLE,
		S_WALK,
		S_WLAT,
		S_POST,
		S_PLAT,
		S_FRD,
		S_FLAT,
		S_WPREV,
		S_SRCH,
		S_SLAT
	} state_t;

	state_t  state_q;
	func_t   func_q;
	data_t   val_q;
	addr_t   cur_q;
	len_t    cnt_q;
	len_t    target_q;
	addr_t   prev_next_q;
	addr_t   node_q;
	addr_t   link_val_q;
	addr_t   head_q;
	addr_t   free_q;
	len_t    len_q;
	logic    done_q;
	status_t status_q;
	logic [VAL_W-1:0] result_q;
	logic [POS_W-1:0] found_q;

	mem_req_t req;
	mem_rsp_t rsp;

	len_t  pos_l;
	addr_t prev_link;
	logic  srch_go;

	function automatic logic node_ok(addr_t a);
		return (a >= FIRST_NODE) && (int'(a) < DEPTH);
	endfunction

	sll_node_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign pos_l     = len_t'(position);
	assign prev_link = (cur_q == NIL) ? head_q : rsp.next;
	assign srch_go   = (cur_q != NIL) && (int'(cur_q) < DEPTH) && (cnt_q <= len_q);

	always_comb begin
		req = '0;
		case (state_q)
			S_WALK: begin
				if (cnt_q != target_q && cur_q != NIL) begin
					req.rd_en   = 1'b1;
					req.rd_addr = cur_q;
				end
			end
			S_POST: begin
				req.rd_en   = 1'b1;
				req.rd_addr = cur_q;
			end
			S_FRD: begin
				req.rd_en   = 1'b1;
				req.rd_addr = node_q;
			end
			S_SRCH: begin
				if (srch_go) begin
					req.rd_en   = 1'b1;
					req.rd_addr = cur_q;
				end
			end
			S_FLAT: begin
				req.wr_next_en = 1'b1;
				req.wr_addr    = node_q;
				if (func_q == FN_DELETE) begin
					req.wr_next = free_q;
				end else begin
					req.wr_next    = (func_q == FN_APPEND) ? NIL : prev_next_q;
					req.wr_data_en = 1'b1;
					req.wr_data    = val_q;
				end
			end
			S_WPREV: begin
				req.wr_next_en = 1'b1;
				req.wr_addr    = cur_q;
				req.wr_next    = link_val_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			head_q   <= NIL;
			free_q   <= FIRST_NODE;
			len_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						func_q   <= func_t'(func);
						val_q    <= data_t'(item_value);
						cur_q    <= NIL;
						cnt_q    <= '0;
						result_q <= '0;
						found_q  <= '0;
						case (func_t'(func))
							FN_APPEND: begin
								if (free_q == NIL) begin
									done_q   <= 1'b1;
									status_q <= ST_FULL;
								end else begin
									target_q <= len_q;
									state_q  <= S_WALK;
								end
							end
							FN_INSERT: begin
								if (free_q == NIL) begin
									done_q   <= 1'b1;
									status_q <= ST_FULL;
								end else if (pos_l == '0 || pos_l > len_q + len_t'(1)) begin
									done_q   <= 1'b1;
									status_q <= ST_BADPOS;
								end else begin
									target_q <= pos_l - len_t'(1);
									state_q  <= S_WALK;
								end
							end
							FN_DELETE: begin
								if (len_q == '0) begin
									done_q   <= 1'b1;
									status_q <= ST_EMPTY;
								end else if (pos_l == '0 || pos_l > len_q) begin
									done_q   <= 1'b1;
									status_q <= ST_BADPOS;
								end else begin
									target_q <= pos_l - len_t'(1);
									state_q  <= S_WALK;
								end
							end
							FN_SEARCH: begin
								cur_q   <= head_q;
								cnt_q   <= len_t'(1);
								state_q <= S_SRCH;
							end
							FN_READ: begin
								if (len_q == '0) begin
									done_q   <= 1'b1;
									status_q <= ST_EMPTY;
								end else if (pos_l == '0 || pos_l > len_q) begin
									done_q   <= 1'b1;
									status_q <= ST_BADPOS;
								end else begin
									target_q <= pos_l;
									state_q  <= S_WALK;
								end
							end
							default: begin
								done_q   <= 1'b1;
								status_q <= ST_OK;
							end
						endcase
					end
				end
				S_WALK: begin
					if (cnt_q == target_q) begin
						state_q <= S_POST;
					end else if (cur_q == NIL) begin
						// first hop comes from the head register
						if (head_q == NIL) begin
							state_q <= S_POST;
						end else begin
							cur_q <= head_q;
							cnt_q <= cnt_q + len_t'(1);
						end
					end else begin
						state_q <= S_WLAT;
					end
				end
				S_WLAT: begin
					if (rsp.next == NIL) begin
						state_q <= S_POST;
					end else begin
						cur_q   <= rsp.next;
						cnt_q   <= cnt_q + len_t'(1);
						state_q <= S_WALK;
					end
				end
				S_POST: begin
					state_q <= S_PLAT;
				end
				S_PLAT: begin
					case (func_q)
						FN_READ: begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
							if (!node_ok(cur_q)) begin
								status_q <= ST_BADPOS;
							end else begin
								status_q <= ST_OK;
								result_q <= VAL_W'(rsp.data);
							end
						end
						FN_DELETE: begin
							if (!node_ok(prev_link)) begin
								state_q  <= S_IDLE;
								done_q   <= 1'b1;
								status_q <= ST_BADPOS;
							end else begin
								node_q  <= prev_link;
								state_q <= S_FRD;
							end
						end
						default: begin
							prev_next_q <= prev_link;
							node_q      <= free_q;
							state_q     <= S_FRD;
						end
					endcase
				end
				S_FRD: begin
					state_q <= S_FLAT;
				end
				S_FLAT: begin
					// node write goes out this cycle; the predecessor link follows
					if (func_q == FN_DELETE) begin
						result_q   <= VAL_W'(rsp.data);
						free_q     <= node_q;
						link_val_q <= rsp.next;
						len_q      <= len_q - len_t'(1);
						if (cur_q == NIL) begin
							head_q   <= rsp.next;
							state_q  <= S_IDLE;
							done_q   <= 1'b1;
							status_q <= ST_OK;
						end else begin
							state_q <= S_WPREV;
						end
					end else begin
						free_q     <= rsp.next;
						link_val_q <= node_q;
						len_q      <= len_q + len_t'(1);
						if (cur_q == NIL) begin
							head_q   <= node_q;
							state_q  <= S_IDLE;
							done_q   <= 1'b1;
							status_q <= ST_OK;
						end else begin
							state_q <= S_WPREV;
						end
					end
				end
				S_WPREV: begin
					state_q  <= S_IDLE;
					done_q   <= 1'b1;
					status_q <= ST_OK;
				end
				S_SRCH: begin
					if (srch_go) begin
						state_q <= S_SLAT;
					end else begin
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
						status_q <= ST_NOTFOUND;
					end
				end
				S_SLAT: begin
					if (rsp.data == val_q) begin
						found_q  <= POS_W'(cnt_q);
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
						status_q <= ST_OK;
					end else begin
						cur_q   <= rsp.next;
						cnt_q   <= cnt_q + len_t'(1);
						state_q <= S_SRCH;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy           = (state_q != S_IDLE);
	assign done           = done_q;
	assign status         = status_q;
	assign result_value   = result_q;
	assign found_position = found_q;

	`SLL_ASSERT_NEXT(a_start_moves, start && !busy, busy || done)
	`SLL_ASSERT_SAME(a_done_idle, done, !busy)
	`SLL_ASSERT_SAME(a_len_cap, 1'b1, int'(len_q) <= CAP)
	`SLL_ASSERT_SAME(a_free_empty_full, free_q == NIL, int'(len_q) == CAP)

endmodule

@@ hdl/sll_node_mem.sv @@
// ----------------------------------------------------------------------------
// Node store
// Next-link and data memories, one read and one write address per cycle,
// registered read data. Per-entry valid bits stand in for the reset contents.
// ----------------------------------------------------------------------------
module sll_node_mem (
	input  logic             clk,
	input  logic             arst_n,
	input  sll_pkg::mem_req_t req,
	output sll_pkg::mem_rsp_t rsp
);
	import sll_pkg::*;

	addr_t next_mem [DEPTH];
	data_t data_mem [DEPTH];

	logic [DEPTH-1:0] next_vld_q;
	logic [DEPTH-1:0] data_vld_q;

	addr_t next_rd_q;
	data_t data_rd_q;
	addr_t addr_rd_q;
	logic  next_hit_q;
	logic  data_hit_q;

	// reset link: entry i points at i+1, last entry null
	function automatic addr_t reset_next(addr_t a);
		return (int'(a) + 1 < DEPTH) ? addr_t'(int'(a) + 1) : NIL;
	endfunction

	always_ff @(posedge clk) begin
		if (req.wr_next_en)
			next_mem[req.wr_addr] <= req.wr_next;
		if (req.wr_data_en)
			data_mem[req.wr_addr] <= req.wr_data;
		if (req.rd_en) begin
			next_rd_q <= next_mem[req.rd_addr];
			data_rd_q <= data_mem[req.rd_addr];
			addr_rd_q <= req.rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_vld_q <= '0;
			data_vld_q <= '0;
			next_hit_q <= 1'b0;
			data_hit_q <= 1'b0;
		end else begin
			if (req.wr_next_en)
				next_vld_q[req.wr_addr] <= 1'b1;
			if (req.wr_data_en)
				data_vld_q[req.wr_addr] <= 1'b1;
			if (req.rd_en) begin
				next_hit_q <= next_vld_q[req.rd_addr];
				data_hit_q <= data_vld_q[req.rd_addr];
			end
		end
	end

	assign rsp.next = next_hit_q ? next_rd_q : reset_next(addr_rd_q);
	assign rsp.data = data_hit_q ? data_rd_q : '0;

endmodule

@@ sim/static_linked_list_engine_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Static linked list engine testbench
// Drives append, insert, delete, search, read and unused function codes, with
// random gaps in most phases, keeps a mirror of the node store and free list,
// and checks every result word against the mirror's expected word in order.
// ----------------------------------------------------------------------------
module static_linked_list_engine_tb;
	import sll_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [FUNC_W-1:0]   func = '0;
	logic [POS_W-1:0]    position = '0;
	logic [VAL_W-1:0]    item_value = '0;
	logic                busy;
	logic                done;
	logic [STAT_W-1:0]   status;
	logic [VAL_W-1:0]    result_value;
	logic [POS_W-1:0]    found_position;

	typedef struct {
		logic [STAT_W-1:0] status;
		logic [VAL_W-1:0]  value;
		logic [POS_W-1:0]  found;
	} list_word_t;

	typedef enum {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_t;

	// mirror of the list engine: node store, both heads, element count and
	// the result words still owed by the block
	class list_mirror;
		data_t       node_data [DEPTH];
		addr_t       node_link [DEPTH];
		addr_t       used_head;
		addr_t       free_head;
		int unsigned length;
		list_word_t  pending_words [$];
		int unsigned fail_count;

		function new();
			for (int i = 0; i < DEPTH; i++) begin
				node_data[i] = '0;
				node_link[i] = (i + 1 < DEPTH) ? addr_t'(i + 1) : NIL;
			end
			used_head  = NIL;
			free_head  = FIRST_NODE;
			length     = 0;
			fail_count = 0;
		endfunction

		// nodes 0 and 1 stand for the two list heads
		function addr_t link_of(addr_t n);
			if (n == 0)
				return used_head;
			if (n == 1)
				return free_head;
			return node_link[n];
		endfunction

		function void set_link(addr_t n, addr_t v);
			if (n == 0)
				used_head = v;
			else if (n == 1)
				free_head = v;
			else
				node_link[n] = v;
		endfunction

		function addr_t walk(int unsigned steps);
			addr_t cur;
			addr_t nx;
			cur = '0;
			for (int unsigned k = 0; k < steps && k < DEPTH; k++) begin
				nx = link_of(cur);
				if (nx == NIL)
					break;
				cur = nx;
			end
			return cur;
		endfunction

		function addr_t take_free(data_t v);
			addr_t node;
			node = free_head;
			free_head = link_of(node);
			set_link(node, NIL);
			node_data[node] = v;
			return node;
		endfunction

		function void apply_command(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p,
				logic [VAL_W-1:0] v);
			list_word_t w;
			addr_t      prev;
			addr_t      node;
			addr_t      cur;
			w.status = ST_OK;
			w.value  = '0;
			w.found  = '0;
			case (f)
				FN_APPEND: begin
					if (free_head == NIL)
						w.status = ST_FULL;
					else begin
						prev = walk(length);
						node = take_free(v);
						set_link(prev, node);
						length++;
					end
				end
				FN_INSERT: begin
					if (free_head == NIL)
						w.status = ST_FULL;
					else if (p == 0 || p > length + 1)
						w.status = ST_BADPOS;
					else begin
						prev = walk(p - 1);
						node = take_free(v);
						set_link(node, link_of(prev));
						set_link(prev, node);
						length++;
					end
				end
				FN_DELETE: begin
					if (length == 0)
						w.status = ST_EMPTY;
					else if (p == 0 || p > length)
						w.status = ST_BADPOS;
					else begin
						prev = walk(p - 1);
						node = link_of(prev);
						if (node < 2)
							w.status = ST_BADPOS;
						else begin
							w.value = node_data[node];
							set_link(prev, link_of(node));
							set_link(node, free_head);
							free_head = node;
							length--;
						end
					end
				end
				FN_SEARCH: begin
					w.status = ST_NOTFOUND;
					cur = used_head;
					for (int unsigned k = 1; cur != NIL && k <= length; k++) begin
						if (node_data[cur] == v) begin
							w.status = ST_OK;
							w.found  = k[POS_W-1:0];
							break;
						end
						cur = link_of(cur);
					end
				end
				FN_READ: begin
					if (length == 0)
						w.status = ST_EMPTY;
					else if (p == 0 || p > length)
						w.status = ST_BADPOS;
					else begin
						node = walk(p);
						if (node < 2)
							w.status = ST_BADPOS;
						else
							w.value = node_data[node];
					end
				end
				default: ;
			endcase
			pending_words.push_back(w);
		endfunction

		function void check_word(logic [STAT_W-1:0] st, logic [VAL_W-1:0] val,
				logic [POS_W-1:0] fpos);
			list_word_t w;
			if (pending_words.size() == 0) begin
				$error("result word with no command outstanding");
				fail_count++;
				return;
			end
			w = pending_words.pop_front();
			if (st !== w.status) begin
				$error("status: expected %0d, actual %0d", w.status, st);
				fail_count++;
			end
			if (val !== w.value) begin
				$error("result_value: expected %h, actual %h", w.value, val);
				fail_count++;
			end
			if (fpos !== w.found) begin
				$error("found_position: expected %0d, actual %0d", w.found, fpos);
				fail_count++;
			end
		endfunction
	endclass

	list_mirror mirror = new();
	data_t      value_pool [16];

	static_linked_list_engine uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.func           (func),
		.position       (position),
		.item_value     (item_value),
		.done           (done),
		.status         (status),
		.result_value   (result_value),
		.found_position (found_position)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			mirror.check_word(status, result_value, found_position);
	end

	// wait at falling edges until the block is idle, then present the command;
	// busy cannot rise before the next rising edge, which takes the word
	task automatic send_command(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
			input logic [VAL_W-1:0] v);
		@(negedge clk);
		while (busy) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start      <= 1'b1;
		func       <= f;
		position   <= p;
		item_value <= v;
		@(posedge clk);
		mirror.apply_command(f, p, v);
	endtask

	task automatic idle_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 100);
	endfunction

	function automatic logic [POS_W-1:0] pick_position();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return POS_W'($urandom_range(0, 63));
		return POS_W'($urandom_range(1, mirror.length + 1));
	endfunction

	// mostly pooled words so searches hit, some fully random
	function automatic logic [VAL_W-1:0] pick_value();
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return value_pool[$urandom_range(0, 15)];
	endfunction

	task automatic run_phase(input mix_t mix, input int count, input bit gaps_on);
		int                r;
		logic [FUNC_W-1:0] f;
		int                w_app, w_ins, w_del, w_srch;
		case (mix)
			MIX_FILL:  begin w_app = 50; w_ins = 30; w_del = 5;  w_srch = 7;  end
			MIX_DRAIN: begin w_app = 5;  w_ins = 10; w_del = 60; w_srch = 10; end
			default:   begin w_app = 20; w_ins = 20; w_del = 20; w_srch = 20; end
		endcase
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < w_app)
				f = FN_APPEND;
			else if (r < w_app + w_ins)
				f = FN_INSERT;
			else if (r < w_app + w_ins + w_del)
				f = FN_DELETE;
			else if (r < w_app + w_ins + w_del + w_srch)
				f = FN_SEARCH;
			else if (r < 98)
				f = FN_READ;
			else
				f = FUNC_W'($urandom_range(5, 7));
			send_command(f, pick_position(), pick_value());
			if (gaps_on)
				idle_cycles(pick_gap());
		end
	endtask

	initial begin
		value_pool[0] = '0;
		value_pool[1] = '1;
		for (int i = 2; i < 16; i++)
			value_pool[i] = $urandom;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty list cases
		send_command(FN_READ,   6'd1, '0);
		send_command(FN_DELETE, 6'd1, '0);
		send_command(FN_SEARCH, 6'd0, 32'h0000_0000);
		send_command(FN_INSERT, 6'd0, 32'h1111_1111);
		send_command(FN_INSERT, 6'd2, 32'h2222_2222);
		// build a short list, head and tail inserts
		send_command(FN_APPEND, 6'd0,  32'h0000_0000);
		send_command(FN_APPEND, 6'd63, 32'hFFFF_FFFF);
		send_command(FN_INSERT, 6'd1,  32'hA5A5_A5A5);
		idle_cycles(2);
		send_command(FN_INSERT, 6'd4,  32'h5A5A_5A5A);
		send_command(FN_READ,   6'd0,  '0);
		send_command(FN_READ,   6'd63, '1);
		send_command(FN_READ,   6'd1,  '0);
		send_command(FN_READ,   6'd4,  '0);
		send_command(FN_SEARCH, 6'd0,  32'hFFFF_FFFF);
		send_command(FN_SEARCH, 6'd0,  32'h5A5A_5A5A);
		send_command(FN_SEARCH, 6'd0,  32'h1234_5678);
		send_command(FN_DELETE, 6'd0,  '0);
		send_command(FN_DELETE, 6'd5,  '0);
		send_command(FN_DELETE, 6'd2,  '0);
		send_command(FN_INSERT, 6'd5,  32'h3333_3333);
		// unused codes are ignored
		send_command(3'd5, 6'h3F, '1);
		send_command(3'd6, 6'h2A, 32'hDEAD_BEEF);
		send_command(3'd7, 6'h15, 32'h0F0F_0F0F);
		idle_cycles(1);

		for (int ph = 0; ph < 16; ph++)
			run_phase(mix_t'(ph % 3), 97, (ph % 4) != 3);

		idle_cycles(1);
		while (mirror.pending_words.size() != 0)
			@(posedge clk);
		repeat (2 * DEPTH + 16) @(posedge clk);

		if (mirror.fail_count == 0 && mirror.pending_words.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/sll_pkg.sv
hdl/sll_node_mem.sv
hdl/static_linked_list_engine.sv
sim/static_linked_list_engine_tb.sv
